// ===== hw/rtl/vref_pkg.sv =====
// Shared constants and types for the vector reflection pipeline.
`timescale 1ns / 1ps
package vref_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int MAG_W = 32;
   localparam int WIDE_W = 64;
   localparam int AXES = 3;

   typedef struct packed {
      logic [AXES-1:0][MAG_W-1:0] dir;
      logic [AXES-1:0][MAG_W-1:0] nmag;
      logic [AXES-1:0]            nneg;
      logic                       dneg;
      logic                       zero;
   } vref_side_type;
endpackage

// ===== hw/rtl/vref_front.sv =====
// Front stages: component products, exact dot products and dividend setup.
`timescale 1ns / 1ps
module vref_front import vref_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int QW = WIDE_W + FRAC_BITS + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [AXES-1:0][MAG_W-1:0]    dir,
   input  logic [AXES-1:0][MAG_W-1:0]    norm,
   output logic                          out_valid,
   output logic [WIDE_W-1:0]             out_den,
   output logic [QW-1:0]                 out_num,
   output vref_side_type                 out_side
);
   logic                              a_valid_ff;
   logic [AXES-1:0][WIDE_W-1:0]       pmag_ff, pmag_in;
   logic [AXES-1:0]                   pneg_ff, pneg_in;
   logic [AXES-1:0][WIDE_W-1:0]       sq_ff, sq_in;
   vref_side_type                     side_a_ff, side_a_in;
   logic                              b_valid_ff;
   logic [WIDE_W-1:0]                 den_ff, den_in;
   logic [QW-1:0]                     num_ff, num_in;
   vref_side_type                     side_b_ff, side_b_in;
   logic [AXES-1:0][MAG_W-1:0]        vmag;
   logic [AXES-1:0]                   vneg;
   logic [AXES-1:0][WIDE_W+1:0]       term;
   logic [WIDE_W+1:0]                 dot;
   logic [WIDE_W+1:0]                 dabs;
   logic [WIDE_W+1:0]                 nsq;

   always_comb begin
      side_a_in = '0;
      for (int i = 0; i < AXES; i++) begin
         vneg[i] = dir[i][MAG_W-1];
         vmag[i] = vneg[i] ? (~dir[i] + 1'b1) : dir[i];
         side_a_in.nneg[i] = norm[i][MAG_W-1];
         side_a_in.nmag[i] = side_a_in.nneg[i] ? (~norm[i] + 1'b1) : norm[i];
         side_a_in.dir[i] = dir[i];
         pmag_in[i] = vmag[i] * side_a_in.nmag[i];
         pneg_in[i] = vneg[i] ^ side_a_in.nneg[i];
         sq_in[i] = side_a_in.nmag[i] * side_a_in.nmag[i];
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         term[i] = pneg_ff[i] ? (~{2'b00, pmag_ff[i]} + 1'b1) : {2'b00, pmag_ff[i]};
      end
      dot = term[0] + term[1] + term[2];
      nsq = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
      dabs = dot[WIDE_W+1] ? (~dot + 1'b1) : dot;
      side_b_in = side_a_ff;
      side_b_in.dneg = dot[WIDE_W+1];
      side_b_in.zero = (nsq == '0);
      den_in = nsq[WIDE_W-1:0];
      num_in = {dabs[WIDE_W-1:0], {(FRAC_BITS+1){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pmag_ff <= pmag_in;
         pneg_ff <= pneg_in;
         sq_ff <= sq_in;
         side_a_ff <= side_a_in;
         den_ff <= den_in;
         num_ff <= num_in;
         side_b_ff <= side_b_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_den = den_ff;
   assign out_num = num_ff;
   assign out_side = side_b_ff;
endmodule

// ===== hw/rtl/vref_cell.sv =====
// One restoring division cell: produces one quotient bit and passes on.
`timescale 1ns / 1ps
module vref_cell import vref_pkg::*; #(
   parameter int QW = WIDE_W + FRAC_BITS_DEF + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [WIDE_W-1:0] in_rem,
   input  logic [WIDE_W-1:0] in_den,
   input  logic [QW-1:0]     in_num,
   input  logic [QW-1:0]     in_quo,
   input  vref_side_type     in_side,
   output logic              out_valid,
   output logic [WIDE_W-1:0] out_rem,
   output logic [WIDE_W-1:0] out_den,
   output logic [QW-1:0]     out_num,
   output logic [QW-1:0]     out_quo,
   output vref_side_type     out_side
);
   logic              valid_ff;
   logic [WIDE_W-1:0] rem_ff, rem_in;
   logic [WIDE_W-1:0] den_ff;
   logic [QW-1:0]     num_ff, num_in;
   logic [QW-1:0]     quo_ff, quo_in;
   vref_side_type     side_ff;
   logic [WIDE_W:0]   wide;
   logic [WIDE_W:0]   diff;
   logic              take;

   always_comb begin
      wide = {in_rem, in_num[QW-1]};
      diff = wide - {1'b0, in_den};
      take = (wide >= {1'b0, in_den});
      rem_in = take ? diff[WIDE_W-1:0] : wide[WIDE_W-1:0];
      num_in = {in_num[QW-2:0], 1'b0};
      quo_in = {in_quo[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= in_den;
         num_ff <= num_in;
         quo_ff <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem = rem_ff;
   assign out_den = den_ff;
   assign out_num = num_ff;
   assign out_quo = quo_ff;
   assign out_side = side_ff;
endmodule

// ===== hw/rtl/vref_back.sv =====
// Back stages: scale clamp, scaled normal, subtraction and output saturation.
`timescale 1ns / 1ps
module vref_back import vref_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int QW = WIDE_W + FRAC_BITS + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [QW-1:0]              in_quo,
   input  vref_side_type              in_side,
   output logic                       out_valid,
   output logic [AXES-1:0][MAG_W-1:0] out_refl,
   output logic                       out_zero,
   output logic                       out_sat
);
   localparam int PW = WIDE_W + MAG_W;

   logic                            c_valid_ff, d_valid_ff, e_valid_ff, o_valid_ff;
   logic [WIDE_W-1:0]               smag_ff, smag_in;
   logic                            sat_c_ff, sat_d_ff, sat_e_ff;
   logic                            sat_c_in;
   vref_side_type                   side_c_ff, side_d_ff, side_e_ff;
   logic [AXES-1:0][WIDE_W-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [AXES-1:0][PW:0]           sp_ff, sp_in;
   logic [AXES-1:0][MAG_W-1:0]      refl_ff, refl_in;
   logic                            zero_ff, zero_in;
   logic                            osat_ff, osat_in;
   logic [WIDE_W-1:0]               limit;
   logic [AXES-1:0][PW-1:0]         prod;
   logic signed [PW:0]              tsh [AXES];
   logic signed [PW+1:0]            diff [AXES];
   logic [AXES-1:0]                 clip;

   always_comb begin
      limit = in_side.dneg ? {1'b1, {(WIDE_W-1){1'b0}}} : {1'b0, {(WIDE_W-1){1'b1}}};
      sat_c_in = (in_quo > {{(QW-WIDE_W){1'b0}}, limit});
      smag_in = sat_c_in ? limit : in_quo[WIDE_W-1:0];
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         lo_in[i] = smag_ff[MAG_W-1:0] * side_c_ff.nmag[i];
         hi_in[i] = smag_ff[WIDE_W-1:MAG_W] * side_c_ff.nmag[i];
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         prod[i] = {{MAG_W{1'b0}}, lo_ff[i]} + {hi_ff[i], {MAG_W{1'b0}}};
         sp_in[i] = (side_d_ff.dneg ^ side_d_ff.nneg[i]) ? (~{1'b0, prod[i]} + 1'b1)
                                                         : {1'b0, prod[i]};
      end
   end

   always_comb begin
      osat_in = sat_e_ff;
      zero_in = side_e_ff.zero;
      for (int i = 0; i < AXES; i++) begin
         tsh[i] = $signed(sp_ff[i]) >>> FRAC_BITS;
         diff[i] = $signed({{(PW+2-MAG_W){side_e_ff.dir[i][MAG_W-1]}}, side_e_ff.dir[i]})
                   - $signed({tsh[i][PW], tsh[i]});
         clip[i] = !((diff[i][PW+1:MAG_W-1] == '0) || (&diff[i][PW+1:MAG_W-1]));
         if (side_e_ff.zero) begin
            refl_in[i] = side_e_ff.dir[i];
         end else if (clip[i]) begin
            refl_in[i] = diff[i][PW+1] ? {1'b1, {(MAG_W-1){1'b0}}} : {1'b0, {(MAG_W-1){1'b1}}};
         end else begin
            refl_in[i] = diff[i][MAG_W-1:0];
         end
      end
      if (side_e_ff.zero) begin
         osat_in = 1'b0;
      end else if (|clip) begin
         osat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= in_valid;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         o_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         smag_ff <= smag_in;
         sat_c_ff <= sat_c_in;
         side_c_ff <= in_side;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         sat_d_ff <= sat_c_ff;
         side_d_ff <= side_c_ff;
         sp_ff <= sp_in;
         sat_e_ff <= sat_d_ff;
         side_e_ff <= side_d_ff;
         refl_ff <= refl_in;
         zero_ff <= zero_in;
         osat_ff <= osat_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_refl = refl_ff;
   assign out_zero = zero_ff;
   assign out_sat = osat_ff;

   a_zero_not_sat: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff && zero_ff |-> !osat_ff)
      else $error("zero normal result flagged as saturated");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(e_valid_ff) && $stable(sp_ff))
      else $error("pipeline stage moved while stalled");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !o_valid_ff)
      else $error("result valid right after reset");
endmodule

// ===== hw/rtl/vector_reflect.sv =====
// Top level of the vector reflection pipeline.
`timescale 1ns / 1ps
// Reflects a Q16.16 direction about an arbitrary, non-unit normal as
// r = v - 2(v.n)/(n.n) n, with exact dot products, a truncated scale and
// saturating outputs. One transaction is accepted every cycle unless the
// result is stalled. The pipeline holds two front stages, one quotient cell
// per quotient bit in a chain of 65 + FRAC_BITS division cells, and four
// output stages. A stalled result freezes the whole pipeline.
module vector_reflect import vref_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [MAG_W-1:0] req_dir_x,
   input  logic signed [MAG_W-1:0] req_dir_y,
   input  logic signed [MAG_W-1:0] req_dir_z,
   input  logic signed [MAG_W-1:0] req_norm_x,
   input  logic signed [MAG_W-1:0] req_norm_y,
   input  logic signed [MAG_W-1:0] req_norm_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [MAG_W-1:0] rsp_refl_x,
   output logic signed [MAG_W-1:0] rsp_refl_y,
   output logic signed [MAG_W-1:0] rsp_refl_z,
   output logic                    rsp_zero_normal,
   output logic                    rsp_saturated
);
   localparam int QW = WIDE_W + FRAC_BITS + 1;

   logic                       en;
   logic [AXES-1:0][MAG_W-1:0] dir, norm, refl;
   logic                       valid_w [QW+1];
   logic [WIDE_W-1:0]          rem_w [QW+1];
   logic [WIDE_W-1:0]          den_w [QW+1];
   logic [QW-1:0]              num_w [QW+1];
   logic [QW-1:0]              quo_w [QW+1];
   vref_side_type              side_w [QW+1];

   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign dir = {req_dir_z, req_dir_y, req_dir_x};
   assign norm = {req_norm_z, req_norm_y, req_norm_x};

   vref_front #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .dir(dir), .norm(norm), .out_valid(valid_w[0]), .out_den(den_w[0]),
      .out_num(num_w[0]), .out_side(side_w[0])
   );

   assign rem_w[0] = '0;
   assign quo_w[0] = '0;

   for (genvar g = 0; g < QW; g++) begin : g_cell
      vref_cell #(.QW(QW)) u_cell (
         .clock(clock), .reset(reset), .en(en), .in_valid(valid_w[g]),
         .in_rem(rem_w[g]), .in_den(den_w[g]), .in_num(num_w[g]),
         .in_quo(quo_w[g]), .in_side(side_w[g]),
         .out_valid(valid_w[g+1]), .out_rem(rem_w[g+1]), .out_den(den_w[g+1]),
         .out_num(num_w[g+1]), .out_quo(quo_w[g+1]), .out_side(side_w[g+1])
      );
   end

   vref_back #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
      .clock(clock), .reset(reset), .en(en), .in_valid(valid_w[QW]),
      .in_quo(quo_w[QW]), .in_side(side_w[QW]), .out_valid(rsp_valid),
      .out_refl(refl), .out_zero(rsp_zero_normal), .out_sat(rsp_saturated)
   );

   assign rsp_refl_x = refl[0];
   assign rsp_refl_y = refl[1];
   assign rsp_refl_z = refl[2];
endmodule
